FILE: rtl/mts_pkg.sv
// ----------------------------------------------------------------------------
// mts_pkg
// Shared types and constants for the max-tracking stack.
// ----------------------------------------------------------------------------
package mts_pkg;

    localparam int FIELD_BITS = 32;
    localparam int M_TDATA_BITS = 104;

    typedef enum logic [1:0] {
        STATUS_OK        = 2'd0,
        STATUS_UNDERFLOW = 2'd1,
        STATUS_OVERFLOW  = 2'd2
    } status_t;

    typedef enum logic {
        ACTION_PUSH = 1'b0,
        ACTION_POP  = 1'b1
    } action_t;

endpackage

FILE: rtl/max_tracking_stack_core.sv
// ----------------------------------------------------------------------------
// max_tracking_stack_core
// Signed LIFO stack with a shadow stack that tracks the running maximum.
// Push, underflow and overflow transactions: result registered in the cycle after accept.
// Successful pop: new top read from RAM on accept, result registered in ST_POP_WAIT.
// Throughput: 1 push per cycle while output is free; a pop holds off input in ST_POP_WAIT.
// Reset clears counts, cached tops and output valid; RAM contents are not cleared.
// ----------------------------------------------------------------------------
module max_tracking_stack_core
    import mts_pkg::*;
#(
    parameter int STACK_DEPTH = 64,
    parameter int WORD_BITS   = 32
) (
    input  logic                    aclk,
    input  logic                    aresetn,
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [FIELD_BITS-1:0]   s_tdata,   // [31:0] push_value
    input  logic                    s_tuser,   // [0] action
    output logic                    m_tvalid,
    input  logic                    m_tready,
    // [31:0] popped_value, [63:32] top_value, [95:64] current_max,
    // [96] is_empty, [98:97] status, [103:99] zero
    output logic [M_TDATA_BITS-1:0] m_tdata
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    typedef enum logic {
        ST_IDLE,
        ST_POP_WAIT
    } state_t;

    function automatic logic [FIELD_BITS-1:0] to_out(input logic [WORD_BITS-1:0] w);
        logic signed [WORD_BITS-1:0] s;
        s = w;
        return FIELD_BITS'(s);
    endfunction

    logic [WORD_BITS-1:0] value_mem [STACK_DEPTH];
    logic [WORD_BITS-1:0] max_mem   [STACK_DEPTH];

    state_t               state_reg, state_next;
    logic [CW-1:0]        vcount_reg, vcount_next;
    logic [CW-1:0]        mcount_reg, mcount_next;
    logic [WORD_BITS-1:0] top_reg, top_next;
    logic [WORD_BITS-1:0] maxtop_reg, maxtop_next;
    logic                 pop_dec_reg, pop_dec_next;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [FIELD_BITS-1:0] popped_reg, popped_next;
    logic [FIELD_BITS-1:0] otop_reg, otop_next;
    logic [FIELD_BITS-1:0] omax_reg, omax_next;
    logic                 empty_reg, empty_next;
    status_t              status_reg, status_next;

    logic [WORD_BITS-1:0] vrd_reg, mrd_reg;
    logic                 v_we, m_we;
    logic [CW-1:0]        v_rd_cnt, m_rd_cnt;
    logic                 s_accept;
    logic signed [FIELD_BITS-1:0] in_s;
    logic [WORD_BITS-1:0] word;
    logic                 out_free;

    assign in_s     = s_tdata;
    assign word     = WORD_BITS'(in_s);
    assign out_free = !m_tvalid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE) && out_free;
    assign s_accept = s_tvalid && s_tready;
    assign v_rd_cnt = vcount_reg - CW'(2);
    assign m_rd_cnt = mcount_reg - CW'(2);

    always_comb begin
        state_next    = state_reg;
        vcount_next   = vcount_reg;
        mcount_next   = mcount_reg;
        top_next      = top_reg;
        maxtop_next   = maxtop_reg;
        pop_dec_next  = pop_dec_reg;
        m_tvalid_next = m_tvalid_reg;
        popped_next   = popped_reg;
        otop_next     = otop_reg;
        omax_next     = omax_reg;
        empty_next    = empty_reg;
        status_next   = status_reg;
        v_we          = 1'b0;
        m_we          = 1'b0;

        if (m_tvalid_reg && m_tready) begin
            m_tvalid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_accept) begin
                    if (action_t'(s_tuser) == ACTION_PUSH) begin
                        popped_next   = '0;
                        empty_next    = 1'b0;
                        m_tvalid_next = 1'b1;
                        if (vcount_reg == CW'(STACK_DEPTH)) begin
                            status_next = STATUS_OVERFLOW;
                            otop_next   = to_out(top_reg);
                            omax_next   = to_out(maxtop_reg);
                        end else begin
                            status_next = STATUS_OK;
                            v_we        = 1'b1;
                            vcount_next = vcount_reg + CW'(1);
                            top_next    = word;
                            otop_next   = to_out(word);
                            if (mcount_reg == '0 ||
                                $signed(word) >= $signed(maxtop_reg)) begin
                                m_we        = 1'b1;
                                mcount_next = mcount_reg + CW'(1);
                                maxtop_next = word;
                                omax_next   = to_out(word);
                            end else begin
                                omax_next   = to_out(maxtop_reg);
                            end
                        end
                    end else begin
                        if (vcount_reg == '0) begin
                            status_next   = STATUS_UNDERFLOW;
                            popped_next   = '0;
                            otop_next     = '0;
                            omax_next     = '0;
                            empty_next    = 1'b1;
                            m_tvalid_next = 1'b1;
                        end else begin
                            status_next  = STATUS_OK;
                            popped_next  = to_out(top_reg);
                            vcount_next  = vcount_reg - CW'(1);
                            pop_dec_next = (maxtop_reg == top_reg);
                            if (maxtop_reg == top_reg) begin
                                mcount_next = mcount_reg - CW'(1);
                            end
                            state_next = ST_POP_WAIT;
                        end
                    end
                end
            end
            ST_POP_WAIT: begin
                if (vcount_reg == '0) begin
                    top_next   = '0;
                    otop_next  = '0;
                    omax_next  = '0;
                    empty_next = 1'b1;
                end else begin
                    top_next   = vrd_reg;
                    otop_next  = to_out(vrd_reg);
                    omax_next  = pop_dec_reg ? to_out(mrd_reg) : to_out(maxtop_reg);
                    empty_next = 1'b0;
                end
                if (pop_dec_reg) begin
                    maxtop_next = mrd_reg;
                end
                m_tvalid_next = 1'b1;
                state_next    = ST_IDLE;
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (v_we) begin
            value_mem[vcount_reg[AW-1:0]] <= word;
        end
        vrd_reg <= value_mem[v_rd_cnt[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (m_we) begin
            max_mem[mcount_reg[AW-1:0]] <= word;
        end
        mrd_reg <= max_mem[m_rd_cnt[AW-1:0]];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            vcount_reg   <= '0;
            mcount_reg   <= '0;
            top_reg      <= '0;
            maxtop_reg   <= '0;
            pop_dec_reg  <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            vcount_reg   <= vcount_next;
            mcount_reg   <= mcount_next;
            top_reg      <= top_next;
            maxtop_reg   <= maxtop_next;
            pop_dec_reg  <= pop_dec_next;
            m_tvalid_reg <= m_tvalid_next;
        end
        popped_reg <= popped_next;
        otop_reg   <= otop_next;
        omax_reg   <= omax_next;
        empty_reg  <= empty_next;
        status_reg <= status_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {5'b0, status_reg, empty_reg, omax_reg, otop_reg, popped_reg};

endmodule
